>>> rtl/ssds_pkg.sv
package ssds_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W = 3;

  localparam int N_STATES_DEF = 4;
  localparam int N_INPUTS_DEF = 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [30:0] STEP_RESET = 31'd655;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_LOAD_X = 2'd2;
  localparam logic [1:0] CMD_INPUT  = 2'd3;

  typedef enum logic [1:0] {
    SRC_M,
    SRC_B,
    SRC_X
  } src_t;

  typedef enum logic [1:0] {
    COEF_A,
    COEF_M,
    COEF_AD,
    COEF_BD
  } coef_t;

  typedef enum logic [1:0] {
    DST_M,
    DST_AD,
    DST_BD,
    DST_X
  } dst_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [1:0]               row_index;
    logic [1:0]               col_index;
    logic signed [DATA_W-1:0] value;
    logic                     last_element;
  } item_t;

  typedef struct packed {
    logic [1:0]               state_index;
    logic signed [DATA_W-1:0] state_value;
    logic                     overflow;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic                     wr_a;
    logic                     wr_b;
    logic                     wr_x;
    logic [1:0]               wr_row;
    logic [1:0]               wr_col;
    logic                     init;
    logic                     clr;
    logic                     load;
    src_t                     src;
    logic [IDX_W-1:0]         src_idx;
    logic                     mul;
    logic                     rot;
    coef_t                    coef;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] bcast;
    logic                     wb;
    dst_t                     dst;
    logic                     diag_one;
  } ctl_t;

  function automatic logic [DATA_W:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[DATA_W-1:0]};
    end
  endfunction

endpackage

>>> rtl/ssds_cell.sv
module ssds_cell #(
  parameter int N_STATES = ssds_pkg::N_STATES_DEF,
  parameter int N_INPUTS = ssds_pkg::N_INPUTS_DEF,
  parameter int FRAC_BITS = ssds_pkg::FRAC_BITS_DEF,
  parameter int ID = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ssds_pkg::ctl_t                    ctl,
  input  logic signed [ssds_pkg::DATA_W-1:0] circ_in,
  output logic signed [ssds_pkg::DATA_W-1:0] circ_out,
  output logic signed [ssds_pkg::DATA_W-1:0] x_value,
  output logic                              x_ovf
);
  import ssds_pkg::*;

  localparam int NW = (N_STATES > 1) ? $clog2(N_STATES) : 1;
  localparam int MW = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
  localparam logic [IDX_W-1:0] ID_V = IDX_W'(ID);
  localparam logic [IDX_W:0] N_V = (IDX_W+1)'(N_STATES);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE32 = DATA_W'(ONE64);

  logic signed [DATA_W-1:0] a_row [N_STATES];
  logic signed [DATA_W-1:0] m_row [N_STATES];
  logic signed [DATA_W-1:0] ad_row [N_STATES];
  logic signed [DATA_W-1:0] b_row [N_INPUTS];
  logic signed [DATA_W-1:0] bd_row [N_INPUTS];
  logic signed [DATA_W-1:0] x;
  logic                     ovf;
  logic signed [DATA_W-1:0] circ;
  logic signed [63:0]       prod;
  logic signed [63:0]       acc;
  logic                     mul_d;

  logic [IDX_W:0]           ksum;
  logic [IDX_W-1:0]         kidx;
  logic signed [DATA_W-1:0] coef;
  logic signed [DATA_W-1:0] opd;
  logic signed [63:0]       rnd;
  logic [DATA_W:0]          sat_acc;
  logic [DATA_W:0]          sat_one;
  logic [DATA_W:0]          t_one;
  logic                     diag;
  logic                     row_hit;

  always_comb begin
    ksum = {1'b0, ctl.idx} + {1'b0, ID_V};
    if (ksum >= N_V) begin
      ksum = ksum - N_V;
    end
    kidx = ctl.rot ? ksum[IDX_W-1:0] : ctl.idx;
    case (ctl.coef)
      COEF_A:  coef = a_row[kidx[NW-1:0]];
      COEF_M:  coef = m_row[kidx[NW-1:0]];
      COEF_AD: coef = ad_row[kidx[NW-1:0]];
      COEF_BD: coef = bd_row[kidx[MW-1:0]];
      default: coef = '0;
    endcase
    opd = ctl.rot ? circ : ctl.bcast;
  end

  assign rnd = (prod + HALF) >>> FRAC_BITS;
  assign sat_acc = sat32(acc);
  assign sat_one = sat32(acc + ONE64);
  assign t_one = sat32(64'(signed'(sat_acc[DATA_W-1:0])) + ONE64);
  assign diag = (ctl.idx == ID_V);
  assign row_hit = ({1'b0, ctl.wr_row} == ID_V);

  assign circ_out = circ;
  assign x_value = x;
  assign x_ovf = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_d <= 1'b0;
      x <= '0;
      ovf <= 1'b0;
      for (int j = 0; j < N_STATES; j++) begin
        a_row[j] <= '0;
      end
      for (int j = 0; j < N_INPUTS; j++) begin
        b_row[j] <= '0;
      end
    end else begin
      mul_d <= ctl.mul;
      if (ctl.wr_a && row_hit) begin
        a_row[NW'(ctl.wr_col)] <= ctl.bcast;
      end
      if (ctl.wr_b && row_hit) begin
        b_row[MW'(ctl.wr_col)] <= ctl.bcast;
      end
      if (ctl.wr_x && row_hit) begin
        x <= ctl.bcast;
      end
      if (ctl.wb && ctl.dst == DST_X) begin
        x <= sat_acc[DATA_W-1:0];
        ovf <= sat_acc[DATA_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      case (ctl.src)
        SRC_M:   circ <= m_row[ctl.src_idx[NW-1:0]];
        SRC_B:   circ <= b_row[ctl.src_idx[MW-1:0]];
        default: circ <= x;
      endcase
    end else if (ctl.mul && ctl.rot) begin
      circ <= circ_in;
    end
    if (ctl.mul) begin
      prod <= 64'(coef) * 64'(opd);
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (mul_d) begin
      acc <= acc + rnd;
    end
    if (ctl.init) begin
      for (int j = 0; j < N_STATES; j++) begin
        m_row[j] <= (j == ID) ? ONE32 : '0;
      end
    end
    if (ctl.wb) begin
      case (ctl.dst)
        DST_M: begin
          m_row[ctl.idx[NW-1:0]] <= (ctl.diag_one && diag) ? sat_one[DATA_W-1:0]
                                                            : sat_acc[DATA_W-1:0];
        end
        DST_AD: begin
          ad_row[ctl.idx[NW-1:0]] <= diag ? t_one[DATA_W-1:0] : sat_acc[DATA_W-1:0];
        end
        DST_BD: begin
          bd_row[ctl.idx[MW-1:0]] <= sat_acc[DATA_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/state_space_discrete_stepper.sv
// Discrete state-space stepper, signed fixed point with FRAC_BITS fraction bits.
// Item channel (item_valid/item_stall, payload item): loads entries of A, B and
// the state vector, or input elements; an input element with last_element set
// starts a step. Step-size channel (step_valid/step_ready, step_size) is always
// ready and marks the coefficients stale, as does any in-range A or B load.
// Result channel (result_valid/result_stall, payload result): one transfer per
// state element, index 0 first, last set on the final element.
// A step with fresh coefficients runs the state update in the cell row, one
// multiply per cell per cycle, then emits the state elements in order. A stale
// rebuild first runs the init, three rounds of matrix multiply and scaling, a
// half-step scaling and the Ad and Bd products, column by column through the
// ring of cells.
// item_stall stays high from the start of a step until the last result is
// registered; a stalled receiver holds the result register and the sequencer.
// Reset clears A, B, the state and input vectors, marks coefficients
// stale and sets the step size to 655.
module state_space_discrete_stepper #(
  parameter int N_STATES = ssds_pkg::N_STATES_DEF,
  parameter int N_INPUTS = ssds_pkg::N_INPUTS_DEF,
  parameter int FRAC_BITS = ssds_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ssds_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ssds_pkg::result_t result,
  input  logic              step_valid,
  output logic              step_ready,
  input  logic [30:0]       step_size
);
  import ssds_pkg::*;

  localparam int NW = (N_STATES > 1) ? $clog2(N_STATES) : 1;
  localparam int MW = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
  localparam int TW = $clog2(N_STATES + N_INPUTS + 3) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_MULA,
    S_SCALE,
    S_HSCALE,
    S_AD,
    S_BD,
    S_UPD,
    S_EMIT
  } state_t;

  state_t            state;
  logic [TW-1:0]     t;
  logic [IDX_W-1:0]  col;
  logic [1:0]        rnd;
  logic              coef_valid;
  logic [30:0]       h;
  logic [30:0]       h3;
  logic signed [DATA_W-1:0] u_vec [N_INPUTS];

  ctl_t              ctl;
  logic              item_acc;
  logic              step_acc;
  logic              out_free;
  int                last_t;
  int                last_col;
  logic [IDX_W-1:0]  uidx;
  logic signed [DATA_W-1:0] scale;

  logic signed [DATA_W-1:0] circ [N_STATES];
  logic signed [DATA_W-1:0] x_vals [N_STATES];
  logic                     x_ovfs [N_STATES];

  assign item_acc = item_valid && !item_stall;
  assign step_acc = step_valid && step_ready;
  assign item_stall = (state != S_IDLE);
  assign step_ready = 1'b1;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    case (rnd)
      2'd0:    scale = {3'b000, h[30:2]};
      2'd1:    scale = {1'b0, h3};
      default: scale = {2'b00, h[30:1]};
    endcase
  end

  always_comb begin
    case (state)
      S_SCALE, S_HSCALE: last_t = 3;
      S_UPD:             last_t = N_STATES + N_INPUTS + 2;
      default:           last_t = N_STATES + 2;
    endcase
    case (state)
      S_BD:    last_col = N_INPUTS - 1;
      S_UPD:   last_col = 0;
      default: last_col = N_STATES - 1;
    endcase
    uidx = IDX_W'(int'(t) - N_STATES - 1);
  end

  always_comb begin
    ctl = '0;
    ctl.bcast = item.value;
    ctl.wr_row = item.row_index;
    ctl.wr_col = item.col_index;
    ctl.src_idx = col;
    unique case (state)
      S_IDLE: begin
        if (item_acc) begin
          ctl.wr_a = (item.cmd == CMD_LOAD_A) && (int'(item.row_index) < N_STATES)
                     && (int'(item.col_index) < N_STATES);
          ctl.wr_b = (item.cmd == CMD_LOAD_B) && (int'(item.row_index) < N_STATES)
                     && (int'(item.col_index) < N_INPUTS);
          ctl.wr_x = (item.cmd == CMD_LOAD_X) && (int'(item.row_index) < N_STATES);
        end
      end
      S_INIT: begin
        ctl.init = 1'b1;
      end
      S_SCALE, S_HSCALE: begin
        ctl.coef = COEF_M;
        ctl.idx = col;
        ctl.bcast = (state == S_HSCALE) ? {1'b0, h} : scale;
        ctl.clr = (t == '0);
        ctl.mul = (int'(t) == 1);
        ctl.wb = (int'(t) == last_t);
        ctl.dst = DST_M;
        ctl.diag_one = (state == S_SCALE);
      end
      S_MULA, S_AD, S_BD, S_UPD: begin
        case (state)
          S_BD:    ctl.src = SRC_B;
          S_UPD:   ctl.src = SRC_X;
          default: ctl.src = SRC_M;
        endcase
        ctl.clr = (t == '0);
        ctl.load = (t == '0);
        if (int'(t) >= 1 && int'(t) <= N_STATES) begin
          ctl.mul = 1'b1;
          ctl.rot = 1'b1;
          ctl.idx = IDX_W'(int'(t) - 1);
          case (state)
            S_BD:    ctl.coef = COEF_M;
            S_UPD:   ctl.coef = COEF_AD;
            default: ctl.coef = COEF_A;
          endcase
        end else if (state == S_UPD && int'(t) > N_STATES
                     && int'(t) <= N_STATES + N_INPUTS) begin
          ctl.mul = 1'b1;
          ctl.coef = COEF_BD;
          ctl.idx = uidx;
          ctl.bcast = u_vec[uidx[MW-1:0]];
        end
        if (int'(t) == last_t) begin
          ctl.wb = 1'b1;
          ctl.idx = col;
          case (state)
            S_MULA:  ctl.dst = DST_M;
            S_AD:    ctl.dst = DST_AD;
            S_BD:    ctl.dst = DST_BD;
            default: ctl.dst = DST_X;
          endcase
        end
      end
      S_EMIT: begin
      end
    endcase
  end

  for (genvar i = 0; i < N_STATES; i++) begin : g_cell
    ssds_cell #(
      .N_STATES(N_STATES),
      .N_INPUTS(N_INPUTS),
      .FRAC_BITS(FRAC_BITS),
      .ID(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .circ_in(circ[(i + 1) % N_STATES]),
      .circ_out(circ[i]),
      .x_value(x_vals[i]),
      .x_ovf(x_ovfs[i])
    );
  end

  always_ff @(posedge clk) begin
    h3 <= 31'((64'(h) * 64'h0000_0000_AAAA_AAAB) >> 33);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      t <= '0;
      col <= '0;
      rnd <= '0;
      coef_valid <= 1'b0;
      h <= STEP_RESET;
      result_valid <= 1'b0;
      for (int k = 0; k < N_INPUTS; k++) begin
        u_vec[k] <= '0;
      end
    end else begin
      if (step_acc) begin
        h <= step_size;
        coef_valid <= 1'b0;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (ctl.wr_a || ctl.wr_b) begin
              coef_valid <= 1'b0;
            end
            if (item.cmd == CMD_INPUT) begin
              if (int'(item.col_index) < N_INPUTS) begin
                u_vec[MW'(item.col_index)] <= item.value;
              end
              if (item.last_element) begin
                state <= coef_valid ? S_UPD : S_INIT;
                t <= '0;
                col <= '0;
                rnd <= '0;
              end
            end
          end
        end
        S_INIT: begin
          state <= S_MULA;
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result.state_index <= col[1:0];
            result.state_value <= x_vals[col[NW-1:0]];
            result.overflow <= x_ovfs[col[NW-1:0]];
            result.last <= (int'(col) == N_STATES - 1);
            if (int'(col) == N_STATES - 1) begin
              state <= S_IDLE;
              col <= '0;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        default: begin
          t <= t + 1'b1;
          if (int'(t) == last_t) begin
            t <= '0;
            if (int'(col) == last_col) begin
              col <= '0;
              case (state)
                S_MULA: state <= S_SCALE;
                S_SCALE: begin
                  if (rnd == 2'd2) begin
                    state <= S_HSCALE;
                  end else begin
                    rnd <= rnd + 1'b1;
                    state <= S_MULA;
                  end
                end
                S_HSCALE: state <= S_AD;
                S_AD:     state <= S_BD;
                S_BD: begin
                  state <= S_UPD;
                  coef_valid <= 1'b1;
                end
                default:  state <= S_EMIT;
              endcase
            end else begin
              col <= col + 1'b1;
            end
          end
        end
      endcase
    end
  end

  a_trigger: assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.cmd == CMD_INPUT && item.last_element)
    |=> (state == S_INIT || state == S_UPD))
    else $error("step trigger did not start the sequencer");

  a_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> coef_valid)
    else $error("state update with stale coefficients");

  a_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (result.state_index == 2'(N_STATES - 1)))
    else $error("last flag on wrong state element");

endmodule
